// ===== src/mcw_pkg.sv =====
// ----------------------------------------------------------------------------
// mcw_pkg
// Shared types and constants for the multi-channel watchdog core.
// ----------------------------------------------------------------------------
package mcw_pkg;

    localparam int TIME_W  = 32;
    localparam int CHAN_W  = 4;
    localparam int OP_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER = 2'd0,
        OP_KICK     = 2'd1,
        OP_TICK     = 2'd2,
        OP_CHECK    = 2'd3
    } t_op;

    typedef enum logic {
        ST_DONE    = 1'b0,
        ST_NO_FREE = 1'b1
    } t_status;

    typedef struct packed {
        logic claim;
        logic kick;
    } t_lane_cmd;

endpackage

// ===== src/mcw_stream_if.sv =====
// ----------------------------------------------------------------------------
// mcw_in_if / mcw_out_if
// Valid/ready channels for watchdog commands and results.
// ----------------------------------------------------------------------------
interface mcw_in_if;
    logic                        valid;
    logic                        ready;
    logic [mcw_pkg::OP_W-1:0]    op;
    logic [mcw_pkg::CHAN_W-1:0]  channel;
    logic [mcw_pkg::TIME_W-1:0]  timeout;

    modport source (output valid, output op, output channel, output timeout, input ready);
    modport sink   (input valid, input op, input channel, input timeout, output ready);
endinterface

interface mcw_out_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [mcw_pkg::CHAN_W-1:0]  channel_index;
    logic                        reset_request;

    modport source (output valid, output status, output channel_index, output reset_request,
                    input ready);
    modport sink   (input valid, input status, input channel_index, input reset_request,
                     output ready);
endinterface

// ===== src/multi_channel_watchdog_core.sv =====
// ----------------------------------------------------------------------------
// multi_channel_watchdog_core
// Watchdog channel table with register, kick, tick and check commands.
//
//   channel  | dir | payload                              | results per transfer
//   i_in     | in  | op, channel, timeout                 | -
//   o_out    | out | status, channel_index, reset_request | one per input
//
// An input register feeds the lane compares and two priority encoders, which
// load the result register. A new transfer can be taken every cycle; a
// stalled result holds the input register, and the input register empties as
// soon as the result register frees up.
// Reset clears the tick count, all active flags and both valid flags.
// ----------------------------------------------------------------------------
module multi_channel_watchdog_core #(
    parameter int CHANNELS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mcw_in_if.sink   i_in,
    mcw_out_if.source o_out
);

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                        r_in_valid;
    mcw_pkg::t_op                r_in_op;
    logic [mcw_pkg::CHAN_W-1:0]  r_in_channel;
    logic [mcw_pkg::TIME_W-1:0]  r_in_timeout;

    logic [mcw_pkg::TIME_W-1:0]  r_tick;

    logic                        r_out_valid;
    logic                        r_out_status;
    logic [mcw_pkg::CHAN_W-1:0]  r_out_index;
    logic                        r_out_request;

    logic                        n_status;
    logic [mcw_pkg::CHAN_W-1:0]  n_index;
    logic                        n_request;

    logic                        advance;
    logic [CHANNELS-1:0]         active;
    logic [CHANNELS-1:0]         expired;
    logic                        free_found;
    logic [IW-1:0]               free_index;
    logic                        exp_found;
    logic [IW-1:0]               exp_index;
    mcw_pkg::t_lane_cmd          lane_cmd [CHANNELS];

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_op      <= mcw_pkg::t_op'(i_in.op);
            r_in_channel <= i_in.channel;
            r_in_timeout <= i_in.timeout;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else if (advance && r_in_op == mcw_pkg::OP_TICK) begin
            r_tick <= r_tick + 1'b1;
        end
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        assign lane_cmd[c].claim = advance && (r_in_op == mcw_pkg::OP_REGISTER)
                                   && free_found && (free_index == IW'(c));
        assign lane_cmd[c].kick  = advance && (r_in_op == mcw_pkg::OP_KICK)
                                   && (32'(r_in_channel) == 32'(c));

        mcw_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (lane_cmd[c]),
            .i_tick    (r_tick),
            .i_timeout (r_in_timeout),
            .o_active  (active[c]),
            .o_expired (expired[c])
        );
    end

    mcw_first_set #(.N(CHANNELS)) u_free_enc (
        .i_vec   (~active),
        .o_found (free_found),
        .o_index (free_index)
    );

    mcw_first_set #(.N(CHANNELS)) u_exp_enc (
        .i_vec   (expired),
        .o_found (exp_found),
        .o_index (exp_index)
    );

    always_comb begin
        n_status  = mcw_pkg::ST_DONE;
        n_index   = '0;
        n_request = 1'b0;
        case (r_in_op)
            mcw_pkg::OP_REGISTER: begin
                if (free_found) begin
                    n_index = mcw_pkg::CHAN_W'(free_index);
                end else begin
                    n_status = mcw_pkg::ST_NO_FREE;
                end
            end
            mcw_pkg::OP_CHECK: begin
                if (exp_found) begin
                    n_index   = mcw_pkg::CHAN_W'(exp_index);
                    n_request = 1'b1;
                end
            end
            default: begin
                n_index = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_status  <= n_status;
            r_out_index   <= n_index;
            r_out_request <= n_request;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.channel_index = r_out_index;
    assign o_out.reset_request = r_out_request;

endmodule

// ===== src/mcw_first_set.sv =====
// ----------------------------------------------------------------------------
// mcw_first_set
// Priority encoder: index of the lowest set bit of a vector.
// ----------------------------------------------------------------------------
module mcw_first_set #(
    parameter int N = 16
) (
    input  logic [N-1:0]                          i_vec,
    output logic                                  o_found,
    output logic [((N > 1) ? $clog2(N) : 1)-1:0]  o_index
);

    localparam int IW = (N > 1) ? $clog2(N) : 1;

    always_comb begin
        o_found = |i_vec;
        o_index = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                o_index = IW'(i);
            end
        end
    end

endmodule

// ===== src/mcw_lane.sv =====
// ----------------------------------------------------------------------------
// mcw_lane
// One watchdog channel: active flag, last-kick time, timeout, age compare.
// ----------------------------------------------------------------------------
module mcw_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mcw_pkg::t_lane_cmd          i_cmd,
    input  logic [mcw_pkg::TIME_W-1:0]  i_tick,
    input  logic [mcw_pkg::TIME_W-1:0]  i_timeout,
    output logic                        o_active,
    output logic                        o_expired
);

    logic                        r_active;
    logic [mcw_pkg::TIME_W-1:0]  r_last;
    logic [mcw_pkg::TIME_W-1:0]  r_timeout;
    logic [mcw_pkg::TIME_W-1:0]  age;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cmd.claim) begin
            r_active <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.claim) begin
            r_last    <= i_tick;
            r_timeout <= i_timeout;
        end else if (i_cmd.kick && r_active) begin
            r_last <= i_tick;
        end
    end

    // age wraps modulo 2^32
    assign age       = i_tick - r_last;
    assign o_active  = r_active;
    assign o_expired = r_active && (age > r_timeout);

endmodule

// ===== tb/multi_channel_watchdog_checker.sv =====
// ----------------------------------------------------------------------------
// multi_channel_watchdog_checker
// Watches the command and result channels of the watchdog core and keeps its
// own copy of the channel table. Each accepted command is run through that
// copy to get the result it should produce. Each accepted result is compared
// field by field with the oldest result still outstanding.
// ----------------------------------------------------------------------------
module multi_channel_watchdog_checker #(
    parameter int CHANNELS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mcw_in_if    i_in,
    mcw_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_expired
);
    import mcw_pkg::*;

    typedef struct {
        t_status           status;
        logic [CHAN_W-1:0] index;
        logic              req;
    } wd_result_t;

    logic [TIME_W-1:0] tick_now;
    logic              chan_active [CHANNELS];
    logic [TIME_W-1:0] chan_last_kick [CHANNELS];
    logic [TIME_W-1:0] chan_limit [CHANNELS];
    wd_result_t        outstanding_results [$];

    function automatic wd_result_t advance_watchdog(t_op op, logic [CHAN_W-1:0] chan,
                                                    logic [TIME_W-1:0] tmo);
        wd_result_t        r;
        logic [TIME_W-1:0] age;
        logic              found;
        int                c;
        r = '{ST_DONE, '0, 1'b0};
        found = 1'b0;
        case (op)
            OP_REGISTER: begin
                r.status = ST_NO_FREE;
                for (c = 0; c < CHANNELS; c++) begin
                    if (!found && !chan_active[c]) begin
                        found = 1'b1;
                        chan_active[c] = 1'b1;
                        chan_last_kick[c] = tick_now;
                        chan_limit[c] = tmo;
                        r.status = ST_DONE;
                        r.index = CHAN_W'(c);
                    end
                end
            end
            OP_KICK: begin
                if (int'(chan) < CHANNELS && chan_active[chan])
                    chan_last_kick[chan] = tick_now;
            end
            OP_TICK: begin
                tick_now = tick_now + 1'b1;
            end
            default: begin
                for (c = 0; c < CHANNELS; c++) begin
                    if (!found && chan_active[c]) begin
                        age = tick_now - chan_last_kick[c];
                        if (age > chan_limit[c]) begin
                            found = 1'b1;
                            r.index = CHAN_W'(c);
                            r.req = 1'b1;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        wd_result_t want;
        if (!i_rst_n) begin
            tick_now = '0;
            for (int c = 0; c < CHANNELS; c++) begin
                chan_active[c] = 1'b0;
            end
            outstanding_results.delete();
            o_fail_count = 0;
            o_checked = 0;
            o_expired = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (outstanding_results.size() == 0) begin
                    $error("result transfer with nothing outstanding: status %0d index %0d req %0d",
                           i_out.status, i_out.channel_index, i_out.reset_request);
                    o_fail_count++;
                end else begin
                    want = outstanding_results.pop_front();
                    compare_field("status", want.status, i_out.status);
                    compare_field("channel_index", want.index, i_out.channel_index);
                    compare_field("reset_request", want.req, i_out.reset_request);
                    o_checked++;
                    if (want.req)
                        o_expired++;
                end
            end
            if (i_in.valid && i_in.ready)
                outstanding_results.push_back(advance_watchdog(t_op'(i_in.op), i_in.channel,
                                                               i_in.timeout));
        end
        o_pending = outstanding_results.size();
    end

endmodule

// ===== tb/multi_channel_watchdog_core_tb.sv =====
// ----------------------------------------------------------------------------
// multi_channel_watchdog_core_tb
// Drives register, kick, tick and check commands into the watchdog core: a
// short directed opening on an empty and a partly filled channel table, then
// random traffic that fills the table and keeps channels expiring and being
// kicked, under three idle/stall mixes on the two channels.
// ----------------------------------------------------------------------------
module multi_channel_watchdog_core_tb;
    import mcw_pkg::*;

    localparam int CHANNELS     = 16;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int PHASE_ITEMS  = 360;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cmd_taken;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   cycle_count = 0;
    int   sent_per_op [4];
    int   fail_count;
    int   results_pending;
    int   results_checked;
    int   expirations_seen;

    mcw_in_if  cmd_ch ();
    mcw_out_if res_ch ();

    multi_channel_watchdog_core #(
        .CHANNELS(CHANNELS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    multi_channel_watchdog_checker #(
        .CHANNELS(CHANNELS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (cmd_ch),
        .i_out        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (results_pending),
        .o_checked    (results_checked),
        .o_expired    (expirations_seen)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cmd_taken <= cmd_ch.valid && cmd_ch.ready;
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d results outstanding",
                     cycle_count, results_pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_cmd(t_op op, logic [CHAN_W-1:0] chan, logic [TIME_W-1:0] tmo);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.op      <= op;
        cmd_ch.channel <= chan;
        cmd_ch.timeout <= tmo;
        sent_per_op[op]++;
        do @(negedge i_clk); while (!cmd_taken);
    endtask

    task automatic send_random_cmd();
        int                roll;
        t_op               op;
        logic [TIME_W-1:0] tmo;
        roll = $urandom_range(99);
        tmo = $urandom();
        if (roll < 10) begin
            op = OP_REGISTER;
            case ($urandom_range(9))
                0:       tmo = '0;
                1:       tmo = '1;
                2:       tmo = 32'h8000_0000;
                3:       tmo = $urandom();
                default: tmo = $urandom_range(40);
            endcase
        end else if (roll < 50) begin
            op = OP_KICK;
        end else if (roll < 75) begin
            op = OP_TICK;
        end else begin
            op = OP_CHECK;
        end
        send_cmd(op, CHAN_W'($urandom_range(15)), tmo);
    endtask

    task automatic wait_results_drained();
        cmd_ch.valid <= 1'b0;
        while (results_pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int src_mix [3];
        int sink_mix [3];
        src_mix  = '{27, 59, 0};
        sink_mix = '{59, 27, 0};
        sent_per_op = '{0, 0, 0, 0};
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.op = OP_REGISTER;
        cmd_ch.channel = '0;
        cmd_ch.timeout = '0;
        res_ch.ready = 1'b0;
        src_idle_pct = src_mix[0];
        sink_idle_pct = sink_mix[0];
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table, kicks to unused channels, expiry of a zero timeout
        send_cmd(OP_CHECK, 4'd0, 32'd0);
        send_cmd(OP_KICK, 4'd0, 32'd0);
        send_cmd(OP_KICK, 4'd15, 32'hFFFF_FFFF);
        send_cmd(OP_REGISTER, 4'd0, 32'd0);
        send_cmd(OP_CHECK, 4'd0, 32'd0);
        send_cmd(OP_TICK, 4'd0, 32'd0);
        send_cmd(OP_CHECK, 4'd0, 32'd0);
        send_cmd(OP_KICK, 4'd0, 32'd0);
        send_cmd(OP_CHECK, 4'd0, 32'd0);
        send_cmd(OP_REGISTER, 4'd15, 32'hFFFF_FFFF);
        send_cmd(OP_REGISTER, 4'd0, 32'd1);
        send_cmd(OP_REGISTER, 4'd0, 32'h8000_0000);
        send_cmd(OP_TICK, 4'd0, 32'd0);
        send_cmd(OP_CHECK, 4'd0, 32'd0);
        send_cmd(OP_KICK, 4'd0, 32'd0);
        send_cmd(OP_CHECK, 4'd0, 32'd0);
        send_cmd(OP_TICK, 4'd0, 32'd0);
        send_cmd(OP_KICK, 4'd0, 32'd0);
        send_cmd(OP_CHECK, 4'd0, 32'd0);
        send_cmd(OP_KICK, 4'd2, 32'd0);
        send_cmd(OP_CHECK, 4'd0, 32'd0);
        send_cmd(OP_REGISTER, 4'd0, 32'h7FFF_FFFF);
        send_cmd(OP_TICK, 4'd0, 32'd0);
        send_cmd(OP_KICK, 4'd15, 32'd0);
        send_cmd(OP_CHECK, 4'd0, 32'd0);

        for (int phase = 0; phase < 3; phase++) begin
            wait_results_drained();
            src_idle_pct = src_mix[phase];
            sink_idle_pct = sink_mix[phase];
            repeat (PHASE_ITEMS) send_random_cmd();
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("%0d commands: %0d register, %0d kick, %0d tick, %0d check",
                 sent_per_op[0] + sent_per_op[1] + sent_per_op[2] + sent_per_op[3],
                 sent_per_op[OP_REGISTER], sent_per_op[OP_KICK], sent_per_op[OP_TICK],
                 sent_per_op[OP_CHECK]);
        $display("%0d results compared, %0d reporting an expired channel, %0d mismatches",
                 results_checked, expirations_seen, fail_count);
        if (fail_count == 0 && results_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/mcw_pkg.sv
src/mcw_stream_if.sv
src/mcw_first_set.sv
src/mcw_lane.sv
src/multi_channel_watchdog_core.sv
tb/multi_channel_watchdog_checker.sv
tb/multi_channel_watchdog_core_tb.sv
